### rtl/periodic_oneshot_timer_table_assert.svh
// Assertion macros for the timer table.
// Define NO_ASSERTIONS to compile them out.
`ifndef PERIODIC_ONESHOT_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_ONESHOT_TIMER_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define POTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define POTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define POTT_ASSERT_IMP(lbl, ante, cons, msg)
`define POTT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/potimer_pkg.sv
package potimer_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int MAX_RESULTS     = 16;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W          = 4;
  localparam int RATE_W          = 32;
  localparam int IN_TDATA_W      = 40;
  localparam int OUT_TDATA_W     = 40;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SET,
    OP_REMOVE,
    OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    KIND_FIRE,
    KIND_SET,
    KIND_REMOVE,
    KIND_QUERY
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIND,
    S_QUERY,
    S_RESP
  } state_t;

endpackage

### rtl/potimer_due.sv
// Expiry compare: elapsed time (modulo wrap) strictly above the period.
module potimer_due import potimer_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 act,
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] stamp,
  input  logic [RATE_W-1:0]    period,
  output logic                 due
);

  localparam int CMP_W = (TIME_BITS > RATE_W) ? TIME_BITS : RATE_W;

  logic [TIME_BITS-1:0] elapsed;

  assign elapsed = now - stamp;
  // a period at or above 2^TIME_BITS can never be exceeded
  assign due = act && (CMP_W'(elapsed) > CMP_W'(period));

endmodule

### rtl/periodic_oneshot_timer_table.sv
// Periodic / one-shot timer table.
//
// Input channel (in_*): one item per request. in_tuser carries the opcode
// (tick, set, remove, query); in_tdata carries slot, replace, rate and loop.
// Result channel (out_*): fire results and answers. out_tuser is the kind,
// out_tlast marks the final result caused by an input item.
//
// A tick bumps the time counter and walks the slot table one slot per cycle
// while no stall holds the scan, through a single expiry compare unit; a
// response state follows when something fired. Fires are held one deep so
// the last one can carry tlast. Set with a nonzero rate walks the active
// marks from slot 0 up to the first free slot; remove goes straight to the
// response, query after one registered slot-store read. The slot store is a
// one-write one-read memory; the scan pipelines its reads one slot ahead.
// in_tready is high only while the sequencer is idle.
// Reset (synchronous, rst_n low) clears all active marks, the time counter
// and the output valid; slot contents are not cleared.
// The output register holds a result while the next item is accepted; a
// stalled receiver holds the scan only when a second fire needs the register.
module periodic_oneshot_timer_table import potimer_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // slot[3:0] replace[4] rate_ticks[36:5] loop_mode[37]
  input  logic [1:0]             in_tuser,   // op[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // slot_out[3:0] ok[4] is_loop[5] rate_out[37:6]
  output logic [1:0]             out_tuser,  // kind[1:0]
  output logic                   out_tlast
);

`include "periodic_oneshot_timer_table_assert.svh"

  localparam int IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int SX_W   = IDX_W + SLOT_W;
  localparam int WORD_W = 1 + RATE_W + TIME_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);
  localparam logic [SX_W-1:0]  SLOTS_SX = SX_W'(TIMER_SLOTS);

  // input unpack
  op_t               in_op;
  logic [SLOT_W-1:0] in_slot;
  logic              in_replace;
  logic [RATE_W-1:0] in_rate;
  logic              in_loop;
  logic [SX_W-1:0]   in_sx;
  logic              in_rng;
  logic [IDX_W-1:0]  in_idx;
  logic              in_acc;

  assign in_op      = op_t'(in_tuser);
  assign in_slot    = in_tdata[3:0];
  assign in_replace = in_tdata[4];
  assign in_rate    = in_tdata[36:5];
  assign in_loop    = in_tdata[37];
  assign in_sx      = SX_W'(in_slot);
  assign in_rng     = in_sx < SLOTS_SX;
  assign in_idx     = in_sx[IDX_W-1:0];
  assign in_acc     = in_tvalid && in_tready;

  // control state
  state_t                 state_r, state_nxt;
  logic [TIMER_SLOTS-1:0] active_r, active_nxt;
  logic [TIME_BITS-1:0]   now_r, now_nxt;
  logic                   pend_r, pend_nxt;
  logic [CNT_W-1:0]       fire_cnt_r, fire_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // item and result payload
  op_t               op_r, op_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  sidx_r, sidx_nxt;
  logic              rng_r, rng_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic              loop_r, loop_nxt;
  kind_t             resp_kind_r, resp_kind_nxt;
  logic [SLOT_W-1:0] resp_slot_r, resp_slot_nxt;
  logic              resp_ok_r, resp_ok_nxt;
  logic              resp_loop_r, resp_loop_nxt;
  logic [RATE_W-1:0] resp_rate_r, resp_rate_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic              out_loop_r, out_loop_nxt;
  logic [RATE_W-1:0] out_rate_r, out_rate_nxt;
  logic              out_last_r, out_last_nxt;

  // slot store: {periodic, period, stamp}
  logic [WORD_W-1:0] mem [TIMER_SLOTS];
  logic [WORD_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;

  logic              rd_loop;
  logic [RATE_W-1:0] rd_period;
  logic [TIME_BITS-1:0] rd_stamp;

  assign rd_loop   = rd_data_r[WORD_W-1];
  assign rd_period = rd_data_r[RATE_W+TIME_BITS-1:TIME_BITS];
  assign rd_stamp  = rd_data_r[TIME_BITS-1:0];

  logic due;
  logic out_free;
  logic emit_new;
  logic stall;
  logic q_act;
  logic remove_resp;

  potimer_due #(
    .TIME_BITS (TIME_BITS)
  ) u_due (
    .act    (active_r[idx_r]),
    .now    (now_r),
    .stamp  (rd_stamp),
    .period (rd_period),
    .due    (due)
  );

  assign out_free    = !out_valid_r || out_tready;
  assign in_tready   = (state_r == S_IDLE);
  assign emit_new    = due && (fire_cnt_r < CNT_W'(MAX_RESULTS));
  assign stall       = emit_new && pend_r && !out_free;
  assign q_act       = rng_r && active_r[sidx_r];
  assign remove_resp = (state_r == S_RESP) && (op_r == OP_REMOVE) && rng_r;

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    now_nxt       = now_r;
    pend_nxt      = pend_r;
    fire_cnt_nxt  = fire_cnt_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    sidx_nxt      = sidx_r;
    rng_nxt       = rng_r;
    rate_nxt      = rate_r;
    loop_nxt      = loop_r;
    resp_kind_nxt = resp_kind_r;
    resp_slot_nxt = resp_slot_r;
    resp_ok_nxt   = resp_ok_r;
    resp_loop_nxt = resp_loop_r;
    resp_rate_nxt = resp_rate_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_ok_nxt    = out_ok_r;
    out_loop_nxt  = out_loop_r;
    out_rate_nxt  = out_rate_r;
    out_last_nxt  = out_last_r;
    rd_addr       = idx_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_op;
          sidx_nxt      = in_idx;
          rng_nxt       = in_rng;
          rate_nxt      = in_rate;
          loop_nxt      = in_loop;
          idx_nxt       = '0;
          resp_slot_nxt = '0;
          resp_ok_nxt   = 1'b0;
          resp_loop_nxt = 1'b0;
          resp_rate_nxt = '0;
          case (in_op)
            OP_TICK: begin
              now_nxt       = now_r + 1'b1;
              rd_addr       = '0;
              fire_cnt_nxt  = '0;
              pend_nxt      = 1'b0;
              resp_kind_nxt = KIND_FIRE;
              resp_ok_nxt   = 1'b1;
              state_nxt     = S_SCAN;
            end
            OP_SET: begin
              if (in_replace && in_rng) begin
                active_nxt[in_idx] = 1'b0;
              end
              resp_kind_nxt = KIND_SET;
              // zero rate refuses without a search
              state_nxt = (in_rate == '0) ? S_RESP : S_FIND;
            end
            OP_REMOVE: begin
              resp_kind_nxt = KIND_REMOVE;
              resp_slot_nxt = in_slot;
              resp_ok_nxt   = in_rng && active_r[in_idx];
              if (in_rng) begin
                active_nxt[in_idx] = 1'b0;
              end
              state_nxt = S_RESP;
            end
            OP_QUERY: begin
              rd_addr       = in_idx;
              resp_kind_nxt = KIND_QUERY;
              resp_slot_nxt = in_slot;
              state_nxt     = S_QUERY;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (!stall) begin
          // a newer fire pushes the held one out, not last
          if (emit_new && pend_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_FIRE;
            out_slot_nxt  = resp_slot_r;
            out_ok_nxt    = 1'b1;
            out_loop_nxt  = resp_loop_r;
            out_rate_nxt  = '0;
            out_last_nxt  = 1'b0;
          end
          if (emit_new) begin
            resp_slot_nxt = SLOT_W'(idx_r);
            resp_loop_nxt = rd_loop;
            pend_nxt      = 1'b1;
            fire_cnt_nxt  = fire_cnt_r + 1'b1;
          end
          if (due) begin
            if (rd_loop) begin
              we    = 1'b1;
              waddr = idx_r;
              wdata = {rd_data_r[WORD_W-1:TIME_BITS], now_r};
            end else begin
              active_nxt[idx_r] = 1'b0;
            end
          end
          if (idx_r == LAST_IDX) begin
            pend_nxt  = 1'b0;
            state_nxt = (emit_new || pend_r) ? S_RESP : S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end

      S_FIND: begin
        if (!active_r[idx_r]) begin
          we                = 1'b1;
          waddr             = idx_r;
          wdata             = {loop_r, rate_r, now_r};
          active_nxt[idx_r] = 1'b1;
          resp_ok_nxt       = 1'b1;
          resp_slot_nxt     = SLOT_W'(idx_r);
          state_nxt         = S_RESP;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_RESP;   // table full
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_QUERY: begin
        resp_ok_nxt   = q_act;
        resp_loop_nxt = q_act && rd_loop;
        resp_rate_nxt = q_act ? rd_period : '0;
        state_nxt     = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = resp_kind_r;
          out_slot_nxt  = resp_slot_r;
          out_ok_nxt    = resp_ok_r;
          out_loop_nxt  = resp_loop_r;
          out_rate_nxt  = resp_rate_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      now_r       <= '0;
      pend_r      <= 1'b0;
      fire_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      now_r       <= now_nxt;
      pend_r      <= pend_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    sidx_r      <= sidx_nxt;
    rng_r       <= rng_nxt;
    rate_r      <= rate_nxt;
    loop_r      <= loop_nxt;
    resp_kind_r <= resp_kind_nxt;
    resp_slot_r <= resp_slot_nxt;
    resp_ok_r   <= resp_ok_nxt;
    resp_loop_r <= resp_loop_nxt;
    resp_rate_r <= resp_rate_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_ok_r    <= out_ok_nxt;
    out_loop_r  <= out_loop_nxt;
    out_rate_r  <= out_rate_nxt;
    out_last_r  <= out_last_nxt;
  end

  // slot store, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_rate_r, out_loop_r, out_ok_r, out_slot_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `POTT_ASSERT_NXT(a_busy_after_accept, in_acc, state_r != S_IDLE, "idle after accept")
  `POTT_ASSERT_IMP(a_fire_cap, 1'b1, fire_cnt_r <= CNT_W'(MAX_RESULTS), "fire count overrun")
  `POTT_ASSERT_IMP(a_pend_in_scan, pend_r, state_r == S_SCAN, "held fire outside scan")
  `POTT_ASSERT_IMP(a_mid_fire, out_valid_r && !out_last_r, out_kind_r == KIND_FIRE, "non-fire")
  `POTT_ASSERT_IMP(a_remove_clears, remove_resp, !active_r[sidx_r], "removed slot active")

endmodule
